FILE: rtl/rcbf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcbf_pkg
// Shared types, constants and pixel arithmetic for the RGBA canvas fill unit.
// ----------------------------------------------------------------------------
package rcbf_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int AW  = XW + YW;
    localparam int SZW = 9;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_BLEND = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [14:0]        rect_width;
        logic [14:0]        rect_height;
        logic [31:0]        color_rgba;
    } t_in_item;

    typedef struct packed {
        logic [31:0] pixel_rgba;
        logic        in_range;
    } t_out_item;

    typedef struct packed {
        logic          wr_en;
        logic          wr_color;
        logic          rd_en;
        logic          blend;
        logic [AW-1:0] addr;
        logic          done;
        logic          ret_pixel;
        logic [31:0]   color;
    } t_dp_cmd;

    // Exact floor(x / 255) for any x up to 255 * 256 - 1, which covers every
    // blend sum.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = 17'(x) + 17'(x[15:8]) + 17'd1;
        return t[15:8];
    endfunction

    function automatic logic [31:0] blend_px(input logic [31:0] dst, input logic [31:0] src);
        logic [7:0]  a;
        logic [7:0]  inv;
        logic [31:0] res;
        a   = src[31:24];
        inv = 8'd255 - a;
        for (int ch = 0; ch < 3; ch++) begin
            res[ch*8 +: 8] = div255(16'(src[ch*8 +: 8] * a) + 16'(dst[ch*8 +: 8] * inv));
        end
        res[31:24] = a + div255(16'(dst[31:24] * inv));
        return res;
    endfunction

    function automatic logic [SZW-1:0] clamp_size(input logic [SZW-1:0] v, input int maxv);
        logic [SZW-1:0] s;
        s = (v == '0) ? SZW'(1) : v;
        if (s > SZW'(maxv)) begin
            s = SZW'(maxv);
        end
        return s;
    endfunction

endpackage

FILE: rtl/rcbf_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcbf_dp
// Frame store, read-modify-write blend pipeline and result register.
// ----------------------------------------------------------------------------
module rcbf_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rcbf_pkg::t_dp_cmd  i_cmd,
    output logic               o_done,
    output rcbf_pkg::t_out_item o_result
);

    logic [31:0] mem [0:(1 << rcbf_pkg::AW) - 1];

    logic [31:0]             r_rdata;
    logic                    r_bl_pend;
    logic [rcbf_pkg::AW-1:0] r_bl_addr;
    logic                    r_done;
    rcbf_pkg::t_out_item     r_result;

    logic                    w_we;
    logic [rcbf_pkg::AW-1:0] w_wa;
    logic [31:0]             w_wd;

    // A blend write lands in the cycle after its read, on an address the walk has left.
    always_comb begin
        w_we = i_cmd.wr_en | r_bl_pend;
        w_wa = r_bl_pend ? r_bl_addr : i_cmd.addr;
        if (r_bl_pend) begin
            w_wd = rcbf_pkg::blend_px(r_rdata, i_cmd.color);
        end else begin
            w_wd = i_cmd.wr_color ? i_cmd.color : 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_wa] <= w_wd;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= mem[i_cmd.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_bl_addr <= i_cmd.addr;
        if (i_cmd.done) begin
            r_result.pixel_rgba <= i_cmd.ret_pixel ? r_rdata : 32'd0;
            r_result.in_range   <= i_cmd.ret_pixel;
        end
        if (!i_rst_n) begin
            r_bl_pend <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_bl_pend <= i_cmd.rd_en & i_cmd.blend;
            r_done    <= i_cmd.done;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

FILE: rtl/rcbf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcbf_ctrl
// Sequencer: clips rectangles, walks pixel areas and orders reads and results.
// ----------------------------------------------------------------------------
module rcbf_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  rcbf_pkg::t_in_item       i_item,
    input  logic                     i_cfg_wr,
    input  logic [rcbf_pkg::SZW-1:0] i_cw,
    input  logic [rcbf_pkg::SZW-1:0] i_ch,
    output logic                     o_busy,
    output rcbf_pkg::t_dp_cmd        o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_READ,
        ST_RESULT
    } t_state;

    typedef enum logic [1:0] {
        WK_ZERO,
        WK_COLOR,
        WK_BLEND
    } t_walk;

    t_state                   r_state;
    t_walk                    r_mode;
    logic [rcbf_pkg::SZW-1:0] r_x;
    logic [rcbf_pkg::SZW-1:0] r_y;
    logic [rcbf_pkg::SZW-1:0] r_x0;
    logic [rcbf_pkg::SZW-1:0] r_xe;
    logic [rcbf_pkg::SZW-1:0] r_ye;
    logic                     r_inr;
    logic [31:0]              r_color;

    logic [14:0]        w_left;
    logic [14:0]        w_top;
    logic signed [17:0] w_right;
    logic signed [17:0] w_bottom;
    logic signed [17:0] w_right_c;
    logic signed [17:0] w_bottom_c;
    logic               w_empty;
    logic               w_inr;
    logic               w_x_last;
    logic               w_y_last;

    always_comb begin
        w_left   = i_item.pos_x[15] ? 15'd0 : i_item.pos_x[14:0];
        w_top    = i_item.pos_y[15] ? 15'd0 : i_item.pos_y[14:0];
        w_right  = 18'(i_item.pos_x) + $signed({3'b000, i_item.rect_width});
        w_bottom = 18'(i_item.pos_y) + $signed({3'b000, i_item.rect_height});
        w_right_c  = (w_right > $signed(18'(i_cw))) ? $signed(18'(i_cw)) : w_right;
        w_bottom_c = (w_bottom > $signed(18'(i_ch))) ? $signed(18'(i_ch)) : w_bottom;
        w_empty  = (i_item.rect_width == '0) || (i_item.rect_height == '0) ||
                   ($signed({3'b000, w_left}) >= w_right_c) ||
                   ($signed({3'b000, w_top}) >= w_bottom_c);
        w_inr    = !i_item.pos_x[15] && !i_item.pos_y[15] &&
                   (i_item.pos_x[14:0] < 15'(i_cw)) && (i_item.pos_y[14:0] < 15'(i_ch));
        w_x_last = (rcbf_pkg::SZW'(r_x + 1'b1) == r_xe);
        w_y_last = (rcbf_pkg::SZW'(r_y + 1'b1) == r_ye);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // Power-up sweep zeroes the whole store.
            r_state <= ST_WALK;
            r_mode  <= WK_ZERO;
            r_x     <= '0;
            r_y     <= '0;
            r_x0    <= '0;
            r_xe    <= rcbf_pkg::SZW'(rcbf_pkg::MAX_WIDTH);
            r_ye    <= rcbf_pkg::SZW'(rcbf_pkg::MAX_HEIGHT);
            r_inr   <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_cfg_wr) begin
                        r_state <= ST_WALK;
                        r_mode  <= WK_ZERO;
                        r_x     <= '0;
                        r_y     <= '0;
                        r_x0    <= '0;
                        r_xe    <= rcbf_pkg::SZW'(rcbf_pkg::MAX_WIDTH);
                        r_ye    <= rcbf_pkg::SZW'(rcbf_pkg::MAX_HEIGHT);
                    end else if (i_start) begin
                        r_color <= i_item.color_rgba;
                        r_inr   <= 1'b0;
                        case (i_item.op)
                            rcbf_pkg::OP_CLEAR: begin
                                r_state <= ST_WALK;
                                r_mode  <= WK_COLOR;
                                r_x     <= '0;
                                r_y     <= '0;
                                r_x0    <= '0;
                                r_xe    <= i_cw;
                                r_ye    <= i_ch;
                            end
                            rcbf_pkg::OP_BLEND: begin
                                if (w_empty) begin
                                    r_state <= ST_RESULT;
                                end else begin
                                    r_state <= ST_WALK;
                                    r_mode  <= WK_BLEND;
                                    r_x     <= w_left[rcbf_pkg::SZW-1:0];
                                    r_y     <= w_top[rcbf_pkg::SZW-1:0];
                                    r_x0    <= w_left[rcbf_pkg::SZW-1:0];
                                    r_xe    <= w_right_c[rcbf_pkg::SZW-1:0];
                                    r_ye    <= w_bottom_c[rcbf_pkg::SZW-1:0];
                                end
                            end
                            rcbf_pkg::OP_READ: begin
                                r_state <= ST_READ;
                                r_inr   <= w_inr;
                                r_x     <= i_item.pos_x[rcbf_pkg::SZW-1:0];
                                r_y     <= i_item.pos_y[rcbf_pkg::SZW-1:0];
                            end
                            default: begin
                                r_state <= ST_RESULT;
                            end
                        endcase
                    end
                end
                ST_WALK: begin
                    if (w_x_last) begin
                        r_x <= r_x0;
                        r_y <= rcbf_pkg::SZW'(r_y + 1'b1);
                        if (w_y_last) begin
                            case (r_mode)
                                WK_BLEND: r_state <= ST_DRAIN;
                                WK_COLOR: r_state <= ST_RESULT;
                                default:  r_state <= ST_IDLE;
                            endcase
                        end
                    end else begin
                        r_x <= rcbf_pkg::SZW'(r_x + 1'b1);
                    end
                end
                ST_DRAIN:  r_state <= ST_RESULT;
                ST_READ:   r_state <= ST_RESULT;
                ST_RESULT: r_state <= ST_IDLE;
                default:   r_state <= ST_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd.addr      = {r_y[rcbf_pkg::YW-1:0], r_x[rcbf_pkg::XW-1:0]};
        o_cmd.wr_en     = (r_state == ST_WALK) && (r_mode != WK_BLEND);
        o_cmd.wr_color  = (r_mode == WK_COLOR);
        o_cmd.blend     = (r_state == ST_WALK) && (r_mode == WK_BLEND);
        o_cmd.rd_en     = o_cmd.blend || ((r_state == ST_READ) && r_inr);
        o_cmd.done      = (r_state == ST_RESULT);
        o_cmd.ret_pixel = r_inr;
        o_cmd.color     = r_color;
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

FILE: rtl/rgba_canvas_blend_fill_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgba_canvas_blend_fill_unit
// RGBA8 canvas engine: clear, source-over rectangle blend and pixel read.
// ----------------------------------------------------------------------------
// A read passes the READ and RESULT states before its result strobe; a blend
// walks its clipped pixels and drains the last write; a clear walks
// width*height pixels; an empty rectangle or unused op goes straight to RESULT.
// The walk moves one pixel per cycle, set by the single write port of the
// frame store. busy stays high for the whole item. Reset is synchronous; after
// reset and after a size register write while idle, a clearing pass zeroes the
// store while busy is high. Results are strobes the receiver cannot stall.
// ----------------------------------------------------------------------------
module rgba_canvas_blend_fill_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  rcbf_pkg::t_in_item  i_cmd,
    output logic                o_done,
    output rcbf_pkg::t_out_item o_result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    // Raw register contents (low 9 bits of the write), read back as written.
    logic [rcbf_pkg::SZW-1:0] r_cfg_w;
    logic [rcbf_pkg::SZW-1:0] r_cfg_h;
    logic                     w_cfg_wr;
    logic [rcbf_pkg::SZW-1:0] w_cw;
    logic [rcbf_pkg::SZW-1:0] w_ch;
    rcbf_pkg::t_dp_cmd        w_cmd;

    // Registers sit at byte offsets 0 and 4; bit 2 picks the register.
    assign w_cfg_wr = psel & penable & pwrite;
    assign pready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= rcbf_pkg::SZW'(256);
            r_cfg_h <= rcbf_pkg::SZW'(256);
        end else if (w_cfg_wr) begin
            if (paddr[2] == rcbf_pkg::REG_WIDTH) begin
                r_cfg_w <= pwdata[rcbf_pkg::SZW-1:0];
            end else begin
                r_cfg_h <= pwdata[rcbf_pkg::SZW-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == rcbf_pkg::REG_HEIGHT) begin
            prdata = 32'(r_cfg_h);
        end else begin
            prdata = 32'(r_cfg_w);
        end
    end

    // Sizes in use: zero counts as one, large values saturate at the store size.
    assign w_cw = rcbf_pkg::clamp_size(r_cfg_w, rcbf_pkg::MAX_WIDTH);
    assign w_ch = rcbf_pkg::clamp_size(r_cfg_h, rcbf_pkg::MAX_HEIGHT);

    rcbf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_item   (i_cmd),
        .i_cfg_wr (w_cfg_wr),
        .i_cw     (w_cw),
        .i_ch     (w_ch),
        .o_busy   (busy),
        .o_cmd    (w_cmd)
    );

    rcbf_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule
